>>> rtl/kfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kfd_pkg;

   // Longest payload kept per frame; further bytes are dropped.
   localparam int MAX_FRAME = 256;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);

   localparam int HW_BYTES  = 5;
   localparam int HW_IDX_W  = $clog2(HW_BYTES);

   localparam int RSP_DATA_W = 64;

   localparam logic [7:0] FEND_CODE  = 8'hC0;
   localparam logic [7:0] FESC_CODE  = 8'hDB;
   localparam logic [7:0] TFEND_CODE = 8'hDC;
   localparam logic [7:0] TFESC_CODE = 8'hDD;

   localparam logic CSR_DATA_CMD = 1'b0;
   localparam logic CSR_HW_CMD   = 1'b1;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_SENT = 1'b1;

   typedef enum logic [2:0] {
      EV_PAYLOAD    = 3'd0,
      EV_READY      = 3'd1,
      EV_QUEUE_FULL = 3'd2,
      EV_SETTING    = 3'd3,
      EV_HW_ERROR   = 3'd4
   } event_type;

   typedef enum logic [7:0] {
      SUB_SF      = 8'd0,
      SUB_CR      = 8'd1,
      SUB_BW      = 8'd2,
      SUB_POWER   = 8'd3,
      SUB_FREQ    = 8'd4,
      SUB_SAVE    = 8'd5,
      SUB_RESTORE = 8'd6
   } subcmd_type;

   typedef enum logic [2:0] {
      SET_SF      = 3'd0,
      SET_CR      = 3'd1,
      SET_BW      = 3'd2,
      SET_POWER   = 3'd3,
      SET_FREQ    = 3'd4,
      SET_SAVE    = 3'd5,
      SET_RESTORE = 3'd6
   } setting_type;

   typedef struct packed {
      event_type   ev;
      setting_type id;
      logic [31:0] value;
   } hw_result_type;

endpackage

`default_nettype wire

>>> rtl/kfd_hw_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module kfd_hw_decode (
   input  wire logic [kfd_pkg::HW_BYTES-1:0][7:0] hw_bytes,
   input  wire logic [kfd_pkg::CNT_W-1:0]         count,
   output kfd_pkg::hw_result_type                 result
);
   import kfd_pkg::*;

   logic [31:0] word_value;

   assign word_value = {hw_bytes[1], hw_bytes[2], hw_bytes[3], hw_bytes[4]};

   always_comb begin
      result.ev    = EV_HW_ERROR;
      result.id    = SET_SF;
      result.value = '0;
      // An empty frame has no subcommand byte and falls through to the error.
      if (count != '0) begin
         case (hw_bytes[0])
            SUB_SF, SUB_CR, SUB_POWER: begin
               if (count == CNT_W'(2)) begin
                  result.ev    = EV_SETTING;
                  result.id    = (hw_bytes[0] == SUB_SF) ? SET_SF :
                                 (hw_bytes[0] == SUB_CR) ? SET_CR : SET_POWER;
                  result.value = {24'd0, hw_bytes[1]};
               end
            end
            SUB_BW, SUB_FREQ: begin
               if (count == CNT_W'(5)) begin
                  result.ev    = EV_SETTING;
                  result.id    = (hw_bytes[0] == SUB_BW) ? SET_BW : SET_FREQ;
                  result.value = word_value;
               end
            end
            SUB_SAVE, SUB_RESTORE: begin
               if (count == CNT_W'(1)) begin
                  result.ev = EV_SETTING;
                  result.id = (hw_bytes[0] == SUB_SAVE) ? SET_SAVE : SET_RESTORE;
               end
            end
            default: begin
               result.ev = EV_HW_ERROR;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/kiss_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// An accepted item's result is loaded into the output register in the next cycle.
// Throughput: one item per cycle while no held result stalls the input.
// The output register lets a new item enter while the previous result is taken.
// Reset is synchronous and active high: frame state, pending flag and output valid
// are cleared, the command codes return to their defaults; the hardware byte store is not.
module kiss_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] op
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] byte_value, [15:8] byte_index, [24:16] frame_length,
   // [27:25] setting_id, [59:28] setting_value, [63:60] zero
   output      logic [kfd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic [2:0]  rsp_tuser,   // [2:0] event_res
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [7:0]  csr_wdata
);
   import kfd_pkg::*;

   logic [7:0]       data_code_ff, hw_code_ff;

   logic             in_frame_ff, in_frame_in;
   logic             have_cmd_ff, have_cmd_in;
   logic [7:0]       frame_cmd_ff, frame_cmd_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             esc_ff, esc_in;
   logic             pending_ff, pending_in;
   logic [HW_BYTES-1:0][7:0] hw_bytes_ff;
   logic             hw_we;
   logic [7:0]       value;

   logic             rsp_valid_ff, rsp_valid_in;
   event_type        rsp_ev_ff, rsp_ev_in;
   logic [7:0]       rsp_bv_ff, rsp_bv_in;
   logic [7:0]       rsp_bi_ff, rsp_bi_in;
   logic [8:0]       rsp_fl_ff, rsp_fl_in;
   setting_type      rsp_id_ff, rsp_id_in;
   logic [31:0]      rsp_sv_ff, rsp_sv_in;

   logic             accept;
   logic             is_data, is_hw;
   hw_result_type    hw_res;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_data = (frame_cmd_ff == data_code_ff);
   assign is_hw   = !is_data && (frame_cmd_ff == hw_code_ff);

   kfd_hw_decode u_hw_decode (
      .hw_bytes (hw_bytes_ff),
      .count    (count_ff),
      .result   (hw_res)
   );

   // Unescaped value of the current byte.
   always_comb begin
      value = req_tdata;
      if (esc_ff) begin
         if (req_tdata == TFEND_CODE) begin
            value = FEND_CODE;
         end else if (req_tdata == TFESC_CODE) begin
            value = FESC_CODE;
         end
      end
   end

   always_comb begin
      in_frame_in  = in_frame_ff;
      have_cmd_in  = have_cmd_ff;
      frame_cmd_in = frame_cmd_ff;
      count_in     = count_ff;
      esc_in       = esc_ff;
      pending_in   = pending_ff;
      hw_we        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ev_in    = EV_PAYLOAD;
      rsp_bv_in    = '0;
      rsp_bi_in    = '0;
      rsp_fl_in    = '0;
      rsp_id_in    = SET_SF;
      rsp_sv_in    = '0;

      if (accept) begin
         if (req_tuser == OP_SENT) begin
            pending_in = 1'b0;
         end else if (req_tdata == FEND_CODE) begin
            if (in_frame_ff && have_cmd_ff) begin
               if (is_data) begin
                  rsp_valid_in = 1'b1;
                  if (pending_ff) begin
                     rsp_ev_in = EV_QUEUE_FULL;
                  end else begin
                     pending_in = 1'b1;
                     rsp_ev_in  = EV_READY;
                     rsp_fl_in  = 9'(count_ff);
                  end
               end else if (is_hw) begin
                  rsp_valid_in = 1'b1;
                  rsp_ev_in    = hw_res.ev;
                  rsp_id_in    = hw_res.id;
                  rsp_sv_in    = hw_res.value;
               end
            end
            // Any FEND opens a fresh frame.
            in_frame_in  = 1'b1;
            have_cmd_in  = 1'b0;
            frame_cmd_in = '0;
            count_in     = '0;
            esc_in       = 1'b0;
         end else if (in_frame_ff && (count_ff < CNT_W'(MAX_FRAME))) begin
            if (!have_cmd_ff) begin
               have_cmd_in  = 1'b1;
               frame_cmd_in = req_tdata;
            end else if (is_data || is_hw) begin
               if (!esc_ff && (req_tdata == FESC_CODE)) begin
                  esc_in = 1'b1;
               end else begin
                  esc_in   = 1'b0;
                  count_in = count_ff + CNT_W'(1);
                  if (is_hw) begin
                     hw_we = (count_ff < CNT_W'(HW_BYTES));
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_ev_in    = EV_PAYLOAD;
                     rsp_bv_in    = value;
                     rsp_bi_in    = count_ff[7:0];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_code_ff <= '0;
         hw_code_ff   <= 8'd6;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DATA_CMD: data_code_ff <= csr_wdata;
            CSR_HW_CMD:   hw_code_ff   <= csr_wdata;
            default:      data_code_ff <= data_code_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         have_cmd_ff  <= 1'b0;
         frame_cmd_ff <= '0;
         count_ff     <= '0;
         esc_ff       <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_frame_ff  <= in_frame_in;
         have_cmd_ff  <= have_cmd_in;
         frame_cmd_ff <= frame_cmd_in;
         count_ff     <= count_in;
         esc_ff       <= esc_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hw_we) begin
         hw_bytes_ff[count_ff[HW_IDX_W-1:0]] <= value;
      end
   end

   // Result payload loads only when a new result is produced.
   always_ff @(posedge clock) begin
      if (accept && rsp_valid_in) begin
         rsp_ev_ff <= rsp_ev_in;
         rsp_bv_ff <= rsp_bv_in;
         rsp_bi_ff <= rsp_bi_in;
         rsp_fl_ff <= rsp_fl_in;
         rsp_id_ff <= rsp_id_in;
         rsp_sv_ff <= rsp_sv_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ev_ff;
   assign rsp_tdata  = {4'd0, rsp_sv_ff, rsp_id_ff, rsp_fl_ff, rsp_bi_ff, rsp_bv_ff};

endmodule

`default_nettype wire
